// ----- rtl/core/flight_stick_to_gamepad_mapper_top_macros.svh -----
// assertion macros shared by the checkers of the stick-to-gamepad mapper
// no dependencies; include by bare file name
`ifndef FLIGHT_STICK_TO_GAMEPAD_MAPPER_TOP_MACROS_SVH
`define FLIGHT_STICK_TO_GAMEPAD_MAPPER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FSGM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsgm implication check failed");

// next-cycle implication, disabled while in reset
`define FSGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsgm next-cycle check failed");

`endif

// ----- rtl/core/fsgm_pkg.sv -----
// types, constants and datapath functions of the stick-to-gamepad mapper
// no dependencies; used by the top level
`timescale 1ns / 1ps
`default_nettype none

package fsgm_pkg;

    localparam int AXIS_W        = 16;
    localparam int GAIN_W        = 16;
    localparam int TRIG_W        = 8;
    localparam int HAT_W         = 2;
    localparam int STICK_BUTTONS = 12;
    localparam int BTN_W         = 16;
    localparam int MASKS_PER_REG = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int PROD_W        = 32;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd4096;
    localparam logic [27:0] ONE_Q27 = 28'h800_0000;

    typedef enum logic [2:0] {
        IDX_ROLL_GAIN,
        IDX_PITCH_GAIN,
        IDX_YAW_GAIN,
        IDX_THROTTLE_GAIN,
        IDX_DEAD_BAND,
        IDX_MASKS_LOW,
        IDX_MASKS_MID,
        IDX_MASKS_HIGH
    } reg_idx_t;

    // d-pad bit positions in the report word
    localparam int DPAD_UP    = 0;
    localparam int DPAD_DOWN  = 1;
    localparam int DPAD_LEFT  = 2;
    localparam int DPAD_RIGHT = 3;

    function automatic logic [30:0] prod_mag(logic signed [PROD_W-1:0] prod);
        logic [30:0] mag;
        mag = prod[PROD_W-1] ? 31'(-prod) : 31'(prod);
        return mag;
    endfunction

    // clamp to full scale (one in q27)
    function automatic logic [27:0] clamp_mag(logic [30:0] mag);
        logic [27:0] cm;
        cm = (mag > {3'd0, ONE_Q27}) ? ONE_Q27 : mag[27:0];
        return cm;
    endfunction

    // gained axis to signed 16-bit, dead band tested on the unclamped product
    function automatic logic [AXIS_W-1:0] axis_scale(
        logic signed [PROD_W-1:0] prod,
        logic [15:0]              dead_band
    );
        logic [30:0]       mag;
        logic [27:0]       cm;
        logic [27:0]       neg_sum;
        logic [42:0]       pos_sum;
        logic [AXIS_W-1:0] res;
        mag     = prod_mag(prod);
        cm      = clamp_mag(mag);
        neg_sum = cm + 28'd2048;
        // times 32767 as shift and subtract, half added for rounding
        pos_sum = {cm, 15'd0} - {15'd0, cm} + 43'h400_0000;
        if (mag < {3'd0, dead_band, 12'd0})
        begin
            res = '0;
        end
        else if (prod[PROD_W-1])
        begin
            res = ~neg_sum[27:12] + 16'd1;
        end
        else
        begin
            res = pos_sum[42:27];
        end
        return res;
    endfunction

    // clamped throttle magnitude times 255, rounded
    function automatic logic [TRIG_W-1:0] trig_scale(logic [27:0] q);
        logic [34:0] sum;
        sum = 35'({q, 8'd0}) - 35'(q) + 35'h400_0000;
        return sum[34:27];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/flight_stick_to_gamepad_mapper_top.sv -----
// top level of the flight-stick to gamepad mapper: input register, mapping logic, report register
// depends on fsgm_pkg
`timescale 1ns / 1ps
`default_nettype none

// Flight-stick to gamepad mapper.
// A sample (four Q1.15 axes, hat, 12 stick buttons) enters on the sample channel
// (sample_valid / sample_ready) and one gamepad report leaves on the report
// channel (report_valid / report_ready). Gains, dead band and button masks are
// written over the APB port, 64-bit registers at byte address 8 * index; the user
// must write them only while no item is in flight; the block itself does not enforce it.
// A sample accepted into the input register is mapped by one multiply and a
// clamp/round step per axis, and the result is held in the report register.
// One item per cycle is sustained while the receiver takes every report.
// When the receiver stalls, the report register holds its item and the input
// register still takes one more sample; sample_ready drops only when both are
// full. Reset empties both stages and loads unity gains, zero dead band and
// zero masks.
module flight_stick_to_gamepad_mapper_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fsgm_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [fsgm_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [fsgm_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [fsgm_pkg::AXIS_W-1:0]    roll_in,
    input  logic signed [fsgm_pkg::AXIS_W-1:0]    pitch_in,
    input  logic signed [fsgm_pkg::AXIS_W-1:0]    yaw_in,
    input  logic signed [fsgm_pkg::AXIS_W-1:0]    throttle_in,
    input  logic signed [fsgm_pkg::HAT_W-1:0]     hat_horizontal,
    input  logic signed [fsgm_pkg::HAT_W-1:0]     hat_vertical,
    input  logic [fsgm_pkg::STICK_BUTTONS-1:0]    stick_buttons,
    output logic                                  report_valid,
    input  logic                                  report_ready,
    output logic signed [fsgm_pkg::AXIS_W-1:0]    left_x_axis,
    output logic signed [fsgm_pkg::AXIS_W-1:0]    left_y_axis,
    output logic signed [fsgm_pkg::AXIS_W-1:0]    right_x_axis,
    output logic [fsgm_pkg::TRIG_W-1:0]           right_trigger_out,
    output logic [fsgm_pkg::TRIG_W-1:0]           left_trigger_out,
    output logic [fsgm_pkg::BTN_W-1:0]            report_buttons
);
    import fsgm_pkg::*;

    // low, mid and high mask registers, four buttons each
    localparam int MASK_REGS = 3;

    // configuration registers
    logic signed [GAIN_W-1:0] roll_gain_reg;
    logic signed [GAIN_W-1:0] pitch_gain_reg;
    logic signed [GAIN_W-1:0] yaw_gain_reg;
    logic signed [GAIN_W-1:0] throttle_gain_reg;
    logic [15:0]              dead_band_reg;
    logic [CFG_DATA_W-1:0]    masks_low_reg;
    logic [CFG_DATA_W-1:0]    masks_mid_reg;
    logic [CFG_DATA_W-1:0]    masks_high_reg;
    logic                     cfg_write;
    reg_idx_t                 cfg_idx;

    // input stage
    logic                     in_valid_reg;
    logic signed [AXIS_W-1:0] roll_reg;
    logic signed [AXIS_W-1:0] pitch_reg;
    logic signed [AXIS_W-1:0] yaw_reg;
    logic signed [AXIS_W-1:0] throttle_reg;
    logic signed [HAT_W-1:0]  hat_x_reg;
    logic signed [HAT_W-1:0]  hat_y_reg;
    logic [STICK_BUTTONS-1:0] buttons_reg;

    // report stage
    logic                     out_valid_reg;
    logic signed [AXIS_W-1:0] left_x_reg;
    logic signed [AXIS_W-1:0] left_y_reg;
    logic signed [AXIS_W-1:0] right_x_reg;
    logic [TRIG_W-1:0]        right_trig_reg;
    logic [TRIG_W-1:0]        left_trig_reg;
    logic [BTN_W-1:0]         buttons_out_reg;

    logic                     out_advance;
    logic                     in_advance;
    logic                     sample_take;

    logic signed [PROD_W-1:0] roll_prod;
    logic signed [PROD_W-1:0] pitch_prod;
    logic signed [PROD_W-1:0] yaw_prod;
    logic signed [PROD_W-1:0] throttle_prod;
    logic [27:0]              throttle_mag;
    logic [TRIG_W-1:0]        throttle_trig;
    logic [AXIS_W-1:0]        left_x_next;
    logic [AXIS_W-1:0]        left_y_next;
    logic [AXIS_W-1:0]        right_x_next;
    logic [TRIG_W-1:0]        right_trig_next;
    logic [TRIG_W-1:0]        left_trig_next;
    logic [BTN_W-1:0]         buttons_next;
    logic [CFG_DATA_W-1:0]    mask_bank [MASK_REGS];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_gain_reg     <= GAIN_ONE;
            pitch_gain_reg    <= GAIN_ONE;
            yaw_gain_reg      <= GAIN_ONE;
            throttle_gain_reg <= GAIN_ONE;
            dead_band_reg     <= '0;
            masks_low_reg     <= '0;
            masks_mid_reg     <= '0;
            masks_high_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                IDX_ROLL_GAIN:     roll_gain_reg     <= pwdata[GAIN_W-1:0];
                IDX_PITCH_GAIN:    pitch_gain_reg    <= pwdata[GAIN_W-1:0];
                IDX_YAW_GAIN:      yaw_gain_reg      <= pwdata[GAIN_W-1:0];
                IDX_THROTTLE_GAIN: throttle_gain_reg <= pwdata[GAIN_W-1:0];
                IDX_DEAD_BAND:     dead_band_reg     <= pwdata[15:0];
                IDX_MASKS_LOW:     masks_low_reg     <= pwdata;
                IDX_MASKS_MID:     masks_mid_reg     <= pwdata;
                IDX_MASKS_HIGH:    masks_high_reg    <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            IDX_ROLL_GAIN:     prdata = {48'd0, roll_gain_reg};
            IDX_PITCH_GAIN:    prdata = {48'd0, pitch_gain_reg};
            IDX_YAW_GAIN:      prdata = {48'd0, yaw_gain_reg};
            IDX_THROTTLE_GAIN: prdata = {48'd0, throttle_gain_reg};
            IDX_DEAD_BAND:     prdata = {48'd0, dead_band_reg};
            IDX_MASKS_LOW:     prdata = masks_low_reg;
            IDX_MASKS_MID:     prdata = masks_mid_reg;
            IDX_MASKS_HIGH:    prdata = masks_high_reg;
            default:           prdata = '0;
        endcase
    end

    // two-stage flow control
    assign out_advance  = !out_valid_reg || report_ready;
    assign in_advance   = in_valid_reg && out_advance;
    assign sample_ready = !in_valid_reg || out_advance;
    assign sample_take  = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            roll_reg     <= roll_in;
            pitch_reg    <= pitch_in;
            yaw_reg      <= yaw_in;
            throttle_reg <= throttle_in;
            hat_x_reg    <= hat_horizontal;
            hat_y_reg    <= hat_vertical;
            buttons_reg  <= stick_buttons;
        end
    end

    // mapping logic
    assign roll_prod     = roll_reg * roll_gain_reg;
    assign pitch_prod    = pitch_reg * pitch_gain_reg;
    assign yaw_prod      = yaw_reg * yaw_gain_reg;
    assign throttle_prod = throttle_reg * throttle_gain_reg;

    assign left_x_next  = axis_scale(roll_prod, dead_band_reg);
    assign left_y_next  = axis_scale(pitch_prod, dead_band_reg);
    assign right_x_next = axis_scale(yaw_prod, dead_band_reg);

    assign throttle_mag    = clamp_mag(prod_mag(throttle_prod));
    assign throttle_trig   = trig_scale(throttle_mag);
    assign right_trig_next = throttle_prod[PROD_W-1] ? '0 : throttle_trig;
    assign left_trig_next  = throttle_prod[PROD_W-1] ? throttle_trig : '0;

    assign mask_bank[0] = masks_low_reg;
    assign mask_bank[1] = masks_mid_reg;
    assign mask_bank[2] = masks_high_reg;

    always_comb
    begin
        buttons_next = '0;
        // hat pattern 10 counts as negative
        buttons_next[DPAD_UP]    = !hat_y_reg[HAT_W-1] && (hat_y_reg != '0);
        buttons_next[DPAD_DOWN]  = hat_y_reg[HAT_W-1];
        buttons_next[DPAD_LEFT]  = hat_x_reg[HAT_W-1];
        buttons_next[DPAD_RIGHT] = !hat_x_reg[HAT_W-1] && (hat_x_reg != '0);
        for (int i = 0; i < STICK_BUTTONS; i++)
        begin
            if (buttons_reg[i])
            begin
                buttons_next = buttons_next
                    | mask_bank[i / MASKS_PER_REG][(i % MASKS_PER_REG) * BTN_W +: BTN_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            left_x_reg      <= left_x_next;
            left_y_reg      <= left_y_next;
            right_x_reg     <= right_x_next;
            right_trig_reg  <= right_trig_next;
            left_trig_reg   <= left_trig_next;
            buttons_out_reg <= buttons_next;
        end
    end

    assign report_valid      = out_valid_reg;
    assign left_x_axis       = left_x_reg;
    assign left_y_axis       = left_y_reg;
    assign right_x_axis      = right_x_reg;
    assign right_trigger_out = right_trig_reg;
    assign left_trigger_out  = left_trig_reg;
    assign report_buttons    = buttons_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fsgm_checker.sv -----
// port-level checker of the stick-to-gamepad mapper, bound to the top level
// depends on fsgm_pkg and flight_stick_to_gamepad_mapper_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "flight_stick_to_gamepad_mapper_top_macros.svh"

module fsgm_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  sample_valid,
    input wire logic                                  sample_ready,
    input wire logic                                  report_valid,
    input wire logic                                  report_ready,
    input wire logic signed [fsgm_pkg::AXIS_W-1:0]    left_x_axis,
    input wire logic signed [fsgm_pkg::AXIS_W-1:0]    left_y_axis,
    input wire logic signed [fsgm_pkg::AXIS_W-1:0]    right_x_axis,
    input wire logic [fsgm_pkg::TRIG_W-1:0]           right_trigger_out,
    input wire logic [fsgm_pkg::TRIG_W-1:0]           left_trigger_out,
    input wire logic [fsgm_pkg::BTN_W-1:0]            report_buttons
);
    import fsgm_pkg::*;

    logic                                        stalled;
    logic [3*AXIS_W+2*TRIG_W+BTN_W-1:0]          report_word;

    assign stalled     = report_valid && !report_ready;
    assign report_word = {left_x_axis, left_y_axis, right_x_axis, right_trigger_out,
                          left_trigger_out, report_buttons};

    // a stalled report holds still
    `FSGM_ASSERT_NEXT(a_report_hold, clk, rst_n, stalled, report_valid && $stable(report_word))

    // the only source of back pressure is a stalled full report stage
    `FSGM_ASSERT_IMPLY(a_ready_low, clk, rst_n, !sample_ready, stalled)

    // a new report always comes from a sample taken into the input register and then moved to the report register
    `FSGM_ASSERT_IMPLY(a_report_source, clk, rst_n, $rose(report_valid), $past(sample_valid && sample_ready, 2))

    // throttle drives at most one trigger
    `FSGM_ASSERT_IMPLY(a_one_trigger, clk, rst_n, report_valid, right_trigger_out == '0 || left_trigger_out == '0)

endmodule

bind flight_stick_to_gamepad_mapper_top fsgm_checker u_fsgm_checker (.*);

`default_nettype wire
